// ===== rtl/core/dcgr_pkg.sv =====
`default_nettype none

package dcgr_pkg;

  localparam int MAX_STEP   = 5;
  localparam int DEPTH_W    = 16;
  localparam int HIST_N     = MAX_STEP - 1;
  localparam int LA_N       = MAX_STEP;
  localparam int HIST_IDX_W = $clog2(HIST_N);
  localparam int LA_IDX_W   = $clog2(LA_N);
  localparam int STEP_W     = 3;
  localparam int PEND_W     = 3;
  localparam int ROW_W      = 10;
  localparam int ROWS_W     = 11;
  localparam int ROW_LIMIT  = 1024;

  // pair sum and pair count over one pixel window
  localparam int PAIR_W     = 5;
  localparam int SUM_W      = 21;
  localparam int LANE_CNT_W = 3;

  // iterative divider: (sum / 2) / pairs, four quotient bits per cycle
  localparam int DIV_W      = SUM_W - 1;
  localparam int DIV_BITS   = 4;
  localparam int DIV_ROUNDS = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W  = 3;
  localparam int REM_W      = PAIR_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_STEP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_COLUMN = 2'd2;

  localparam logic [STEP_W-1:0]  STEP_RST = 3'd5;
  localparam logic [DEPTH_W-1:0] THR_RST  = 16'd256;
  localparam logic [ROWS_W-1:0]  ROWS_RST = 11'd64;

  typedef struct packed {
    logic accept;
    logic scan_clear;
    logic scan_step;
    logic div_start;
    logic emit;
  } dcgr_cmd_t;

  typedef struct packed {
    logic emit_needed;
    logic center_zero;
    logic scan_last;
    logic pairs_zero;
    logic div_busy;
    logic out_free;
  } dcgr_stat_t;

  function automatic logic [STEP_W-1:0] clamp_step(input logic [STEP_W-1:0] s);
    logic [STEP_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = STEP_W'(1);
    end else if (s > STEP_W'(MAX_STEP)) begin
      r = STEP_W'(MAX_STEP);
    end
    return r;
  endfunction

  function automatic logic [ROWS_W-1:0] clamp_rows(input logic [ROWS_W-1:0] n);
    logic [ROWS_W-1:0] r;
    r = n;
    if (n == '0) begin
      r = ROWS_W'(1);
    end else if (n > ROWS_W'(ROW_LIMIT)) begin
      r = ROWS_W'(ROW_LIMIT);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dcgr_div.sv =====
`default_nettype none

module dcgr_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [dcgr_pkg::DIV_W-1:0]    dividend,
  input  wire logic [dcgr_pkg::PAIR_W-1:0]   divisor,
  output logic                               busy,
  output logic [dcgr_pkg::DEPTH_W-1:0]       quotient
);

  logic [dcgr_pkg::DIV_W-1:0]     work;
  logic [dcgr_pkg::REM_W-1:0]     rem;
  logic [dcgr_pkg::PAIR_W-1:0]    dvs;
  logic [dcgr_pkg::DIV_CNT_W-1:0] cnt;
  logic [dcgr_pkg::DIV_W-1:0]     work_next;
  logic [dcgr_pkg::REM_W-1:0]     rem_next;

  // restoring division, DIV_BITS steps per cycle; quotient bits shift in at the bottom
  always_comb begin
    logic [dcgr_pkg::REM_W:0] trial;
    work_next = work;
    rem_next  = rem;
    for (int b = 0; b < dcgr_pkg::DIV_BITS; b++) begin
      trial     = {rem_next, work_next[dcgr_pkg::DIV_W-1]};
      work_next = {work_next[dcgr_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_next     = dcgr_pkg::REM_W'(trial - {1'b0, dvs});
        work_next[0] = 1'b1;
      end else begin
        rem_next = trial[dcgr_pkg::REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + dcgr_pkg::DIV_CNT_W'(1);
      if (cnt == dcgr_pkg::DIV_CNT_W'(dcgr_pkg::DIV_ROUNDS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient = work[dcgr_pkg::DEPTH_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/dcgr_datapath.sv =====
`default_nettype none

module dcgr_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [dcgr_pkg::STEP_W-1:0]     cfg_step,
  input  wire logic [dcgr_pkg::DEPTH_W-1:0]    cfg_thresh,
  input  wire logic [dcgr_pkg::ROWS_W-1:0]     cfg_rows,
  input  wire logic [dcgr_pkg::DEPTH_W-1:0]    depth_in,
  input  wire dcgr_pkg::dcgr_cmd_t             cmd,
  output dcgr_pkg::dcgr_stat_t                 stat,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [dcgr_pkg::DEPTH_W-1:0]         depth_out,
  output logic                                 was_filled,
  output logic                                 column_end,
  output logic                                 last_of_run
);

  logic [dcgr_pkg::DEPTH_W-1:0] hist [dcgr_pkg::HIST_N];
  logic [dcgr_pkg::DEPTH_W-1:0] la   [dcgr_pkg::LA_N];

  logic [dcgr_pkg::ROW_W-1:0]      row_pos;
  logic [dcgr_pkg::ROW_W-1:0]      p_cur;
  logic                            last_flag;
  logic [dcgr_pkg::PEND_W-1:0]     pending;
  logic [dcgr_pkg::STEP_W-1:0]     col_step;
  logic [dcgr_pkg::ROWS_W-1:0]     col_rows;
  logic [dcgr_pkg::HIST_IDX_W-1:0] scan_idx;
  logic [dcgr_pkg::SUM_W-1:0]      sum_acc;
  logic [dcgr_pkg::PAIR_W-1:0]     pairs_acc;

  // accept side
  logic                            first_row;
  logic [dcgr_pkg::STEP_W-1:0]     step_use;
  logic [dcgr_pkg::ROWS_W-1:0]     rows_use;
  logic [dcgr_pkg::PEND_W-1:0]     pend_base;
  logic                            is_last;

  // emit side
  logic [dcgr_pkg::ROW_W-1:0]      orow;
  logic [dcgr_pkg::PEND_W-1:0]     pend_m1;
  logic                            more_after;
  logic                            col_end;
  logic [dcgr_pkg::DEPTH_W-1:0]    emit_val;
  logic                            emit_filled;

  // scan side
  logic [dcgr_pkg::STEP_W-1:0]     scan_i;
  logic [dcgr_pkg::DEPTH_W-1:0]    prev;
  logic                            i_ok;
  logic [dcgr_pkg::SUM_W-1:0]      step_sum;
  logic [dcgr_pkg::LANE_CNT_W-1:0] step_pairs;

  logic                            div_busy;
  logic [dcgr_pkg::DEPTH_W-1:0]    quotient;

  assign first_row = (row_pos == '0);
  assign step_use  = first_row ? dcgr_pkg::clamp_step(cfg_step) : col_step;
  assign rows_use  = first_row ? dcgr_pkg::clamp_rows(cfg_rows) : col_rows;
  assign pend_base = first_row ? '0 : pending;
  assign is_last   = (({1'b0, row_pos} + dcgr_pkg::ROWS_W'(1)) >= rows_use);

  // row of the oldest held pixel
  assign orow = dcgr_pkg::ROW_W'({1'b0, p_cur} + dcgr_pkg::ROWS_W'(1)
                                 - dcgr_pkg::ROWS_W'(pending));
  assign pend_m1    = pending - dcgr_pkg::PEND_W'(1);
  assign more_after = (pend_m1 != '0) && ((pend_m1 >= col_step) || last_flag);
  assign col_end    = (({1'b0, orow} + dcgr_pkg::ROWS_W'(1)) >= col_rows);

  assign emit_filled = (la[0] == '0) && (pairs_acc != '0);
  assign emit_val    = (la[0] != '0) ? la[0] : (emit_filled ? quotient : '0);

  // one history row per cycle against all look-ahead rows
  always_comb begin
    logic [dcgr_pkg::DEPTH_W-1:0] nxt;
    logic [dcgr_pkg::DEPTH_W-1:0] diff;
    scan_i     = {1'b0, scan_idx} + dcgr_pkg::STEP_W'(1);
    prev       = hist[scan_idx];
    i_ok       = (scan_i < col_step) && (dcgr_pkg::ROW_W'(scan_i) <= orow);
    step_sum   = '0;
    step_pairs = '0;
    for (int j = 1; j < dcgr_pkg::LA_N; j++) begin
      nxt  = la[j];
      diff = (prev > nxt) ? (prev - nxt) : (nxt - prev);
      if (i_ok && (dcgr_pkg::PEND_W'(j) < col_step) && (dcgr_pkg::PEND_W'(j) < pending)
          && (prev != '0) && (nxt != '0) && (diff < cfg_thresh)) begin
        step_sum   = step_sum + dcgr_pkg::SUM_W'(prev) + dcgr_pkg::SUM_W'(nxt);
        step_pairs = step_pairs + dcgr_pkg::LANE_CNT_W'(1);
      end
    end
  end

  dcgr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_acc[dcgr_pkg::SUM_W-1:1]),
    .divisor  (pairs_acc),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos   <= '0;
      p_cur     <= '0;
      last_flag <= 1'b0;
      pending   <= '0;
      col_step  <= dcgr_pkg::clamp_step(dcgr_pkg::STEP_RST);
      col_rows  <= dcgr_pkg::clamp_rows(dcgr_pkg::ROWS_RST);
      scan_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        col_step  <= step_use;
        col_rows  <= rows_use;
        p_cur     <= row_pos;
        last_flag <= is_last;
        pending   <= pend_base + dcgr_pkg::PEND_W'(1);
        row_pos   <= is_last ? '0 : (row_pos + dcgr_pkg::ROW_W'(1));
      end
      if (cmd.scan_clear) begin
        scan_idx <= '0;
      end else if (cmd.scan_step) begin
        scan_idx <= scan_idx + dcgr_pkg::HIST_IDX_W'(1);
      end
      if (cmd.emit) begin
        pending   <= pend_m1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      la[pend_base] <= depth_in;
    end
    if (cmd.scan_clear) begin
      sum_acc   <= '0;
      pairs_acc <= '0;
    end else if (cmd.scan_step) begin
      sum_acc   <= sum_acc + step_sum;
      pairs_acc <= pairs_acc + dcgr_pkg::PAIR_W'(step_pairs);
    end
    if (cmd.emit) begin
      for (int k = dcgr_pkg::HIST_N - 1; k > 0; k--) begin
        hist[k] <= hist[k-1];
      end
      hist[0] <= emit_val;
      for (int k = 0; k < dcgr_pkg::LA_N - 1; k++) begin
        la[k] <= la[k+1];
      end
      depth_out   <= emit_val;
      was_filled  <= emit_filled;
      column_end  <= col_end;
      last_of_run <= !more_after;
    end
  end

  assign stat.emit_needed = (pending != '0) && ((pending >= col_step) || last_flag);
  assign stat.center_zero = (la[0] == '0);
  assign stat.scan_last   = (scan_idx == dcgr_pkg::HIST_IDX_W'(dcgr_pkg::HIST_N - 1));
  assign stat.pairs_zero  = (pairs_acc == '0);
  assign stat.div_busy    = div_busy;
  assign stat.out_free    = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== rtl/core/dcgr_ctrl.sv =====
`default_nettype none

module dcgr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire dcgr_pkg::dcgr_stat_t stat,
  output dcgr_pkg::dcgr_cmd_t       cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_EMIT   = 6'b100000
  } dcgr_state_t;

  dcgr_state_t state;
  dcgr_state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.emit_needed) begin
          cmd.scan_clear = 1'b1;
          state_next     = stat.center_zero ? ST_SCAN : ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.pairs_zero) begin
          state_next = ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/depth_column_gap_repair_unit.sv =====
// Flow: an input item is taken only while idle, and no new item is taken until the held
//   pixels that are due have been emitted. A nonempty pixel goes from the check state to emit;
//   an empty pixel first runs the pair scan (one history row per cycle) and, when neighbor pairs
//   qualify, the iterative divider. Emit waits while the output is stalled.
// Reset (rst, synchronous): configuration back to step 5, threshold 256, 64 rows;
//   row position, held pixels and output valid cleared.
`default_nettype none

module depth_column_gap_repair_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [dcgr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dcgr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [dcgr_pkg::DEPTH_W-1:0]      depth_in,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [dcgr_pkg::DEPTH_W-1:0]           depth_out,
  output logic                                   was_filled,
  output logic                                   column_end,
  output logic                                   last_of_run
);

  logic [dcgr_pkg::STEP_W-1:0]  window_step;
  logic [dcgr_pkg::DEPTH_W-1:0] pair_limit;
  logic [dcgr_pkg::ROWS_W-1:0]  rows_per_column;

  dcgr_pkg::dcgr_cmd_t  cmd;
  dcgr_pkg::dcgr_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_step     <= dcgr_pkg::STEP_RST;
      pair_limit      <= dcgr_pkg::THR_RST;
      rows_per_column <= dcgr_pkg::ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dcgr_pkg::REG_WINDOW_STEP:     window_step     <= cfg_data[dcgr_pkg::STEP_W-1:0];
        dcgr_pkg::REG_PAIR_LIMIT:      pair_limit      <= cfg_data[dcgr_pkg::DEPTH_W-1:0];
        dcgr_pkg::REG_ROWS_PER_COLUMN: rows_per_column <= cfg_data[dcgr_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  dcgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dcgr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_step    (window_step),
    .cfg_thresh  (pair_limit),
    .cfg_rows    (rows_per_column),
    .depth_in    (depth_in),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .depth_out   (depth_out),
    .was_filled  (was_filled),
    .column_end  (column_end),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

// ===== rtl/core/dcgr_checker.sv =====
`default_nettype none

module dcgr_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [dcgr_pkg::DEPTH_W-1:0]  depth_out,
  input wire logic                          was_filled,
  input wire logic                          column_end,
  input wire logic                          last_of_run
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(depth_out) && $stable(was_filled)
                                && $stable(column_end) && $stable(last_of_run))
    else $error("result changed while stalled");

  // an interpolated value is a mean of nonzero depths
  a_fill_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_filled |-> depth_out != '0)
    else $error("filled pixel is zero");

  // the last pixel of a column drains everything held
  a_col_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && column_end |-> last_of_run)
    else $error("column end without last_of_run");

  // after an item is taken, the next one is not taken in the following cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("back-to-back item accepted");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind depth_column_gap_repair_unit dcgr_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .depth_out   (depth_out),
  .was_filled  (was_filled),
  .column_end  (column_end),
  .last_of_run (last_of_run)
);

`default_nettype wire
